### hdl/led_on_blink_fade_off_sequencer_defines.svh
// Assertion macros for the LED phase sequencer.
`ifndef LED_ON_BLINK_FADE_OFF_SEQUENCER_DEFINES_SVH
`define LED_ON_BLINK_FADE_OFF_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hdl/lobfo_pkg.sv
// Types, codes and constants shared by the LED phase sequencer.
`timescale 1ns / 1ps
package lobfo_pkg;
  localparam int TIME_BITS = 32;
  localparam int IN_BITS   = 32;
  localparam int OUT_BITS  = 16;

  typedef logic [TIME_BITS-1:0] time_t;

  localparam logic [1:0] PH_ON    = 2'd0;
  localparam logic [1:0] PH_BLINK = 2'd1;
  localparam logic [1:0] PH_FADE  = 2'd2;
  localparam logic [1:0] PH_OFF   = 2'd3;

  localparam logic [2:0] CFG_ON_DURATION  = 3'd0;
  localparam logic [2:0] CFG_BLINK_PERIOD = 3'd1;
  localparam logic [2:0] CFG_BLINK_TARGET = 3'd2;
  localparam logic [2:0] CFG_FADE_PERIOD  = 3'd3;
  localparam logic [2:0] CFG_FADE_STEP    = 3'd4;
  localparam logic [2:0] CFG_OFF_DURATION = 3'd5;

  localparam logic [7:0] LEVEL_FULL = 8'd255;
  localparam logic [7:0] LEVEL_ZERO = 8'd0;

  typedef struct packed {
    logic [15:0] on_duration;
    logic [15:0] blink_period;
    logic [2:0]  blink_target;
    logic [15:0] fade_period;
    logic [7:0]  fade_step;
    logic [15:0] off_duration;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic               entry_pending;
    time_t              hold_start;
    time_t              blink_last;
    time_t              fade_last;
    logic               blink_level;
    logic [2:0]         blink_tally;
    logic signed [8:0]  brightness;
  } seq_state_t;

  typedef struct packed {
    logic [7:0] level;
    logic       analog;
    logic       written;
    logic [1:0] phase;
  } result_t;

  localparam cfg_t CFG_RESET = '{
    on_duration:  16'd2000,
    blink_period: 16'd750,
    blink_target: 3'd5,
    fade_period:  16'd40,
    fade_step:    8'd5,
    off_duration: 16'd2000
  };

  localparam seq_state_t STATE_RESET = '{
    phase:         PH_ON,
    entry_pending: 1'b1,
    hold_start:    '0,
    blink_last:    '0,
    fade_last:     '0,
    blink_level:   1'b0,
    blink_tally:   3'd0,
    brightness:    9'sd255
  };
endpackage

### hdl/lobfo_step.sv
// Per-tick phase logic: next sequencer state and the drive result.
`timescale 1ns / 1ps
module lobfo_step (
  input  lobfo_pkg::cfg_t       cfg,
  input  lobfo_pkg::seq_state_t cur,
  input  lobfo_pkg::time_t      now,
  output lobfo_pkg::seq_state_t nxt,
  output lobfo_pkg::result_t    res
);
  localparam int PAD = lobfo_pkg::TIME_BITS - 16;

  lobfo_pkg::time_t  hold_base;
  lobfo_pkg::time_t  fade_base;
  lobfo_pkg::time_t  hold_diff;
  lobfo_pkg::time_t  blink_diff;
  lobfo_pkg::time_t  fade_diff;
  lobfo_pkg::time_t  hold_span;
  logic              blink_toggle;
  logic [2:0]        tally_new;
  logic signed [8:0] bright_base;
  logic signed [9:0] bright_new;

  // Entering ON or OFF latches the tick time; entering FADE resets its timer base to 0 and brightness to 255.
  assign hold_base   = cur.entry_pending ? now : cur.hold_start;
  assign fade_base   = cur.entry_pending ? '0 : cur.fade_last;
  assign bright_base = cur.entry_pending ? 9'sd255 : cur.brightness;
  assign hold_diff   = now - hold_base;
  assign blink_diff  = now - cur.blink_last;
  assign fade_diff   = now - fade_base;
  assign hold_span   = (cur.phase == lobfo_pkg::PH_ON) ?
                       {{PAD{1'b0}}, cfg.on_duration} : {{PAD{1'b0}}, cfg.off_duration};
  assign blink_toggle = blink_diff >= {{PAD{1'b0}}, cfg.blink_period};
  assign tally_new   = (blink_toggle && !cur.blink_level) ? cur.blink_tally + 3'd1
                                                          : cur.blink_tally;
  assign bright_new  = {bright_base[8], bright_base} - $signed({2'b00, cfg.fade_step});

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cur.phase)
      lobfo_pkg::PH_ON, lobfo_pkg::PH_OFF: begin
        nxt.entry_pending = 1'b0;
        nxt.hold_start    = hold_base;
        res.written       = 1'b1;
        res.level         = (cur.phase == lobfo_pkg::PH_ON) ? lobfo_pkg::LEVEL_FULL
                                                            : lobfo_pkg::LEVEL_ZERO;
        if (hold_diff >= hold_span) begin
          nxt.entry_pending = 1'b1;
          nxt.phase = (cur.phase == lobfo_pkg::PH_ON) ? lobfo_pkg::PH_BLINK
                                                      : lobfo_pkg::PH_ON;
        end
      end
      lobfo_pkg::PH_BLINK: begin
        nxt.entry_pending = 1'b0;
        nxt.blink_tally   = tally_new;
        if (blink_toggle) begin
          nxt.blink_last  = now;
          nxt.blink_level = !cur.blink_level;
          res.written     = 1'b1;
          res.level       = cur.blink_level ? lobfo_pkg::LEVEL_ZERO : lobfo_pkg::LEVEL_FULL;
        end
        // Compare on every blink tick, toggled or not.
        if (tally_new == cfg.blink_target) begin
          nxt.entry_pending = 1'b1;
          nxt.blink_tally   = 3'd0;
          nxt.phase         = lobfo_pkg::PH_FADE;
        end
      end
      default: begin
        nxt.entry_pending = 1'b0;
        nxt.fade_last     = fade_base;
        nxt.brightness    = bright_base;
        if (fade_diff >= {{PAD{1'b0}}, cfg.fade_period}) begin
          nxt.fade_last  = now;
          nxt.brightness = bright_new[8:0];
          res.written    = 1'b1;
          res.analog     = 1'b1;
          res.level      = bright_base[7:0];
          if (bright_new[9] || bright_new == 10'sd0) begin
            res.level         = lobfo_pkg::LEVEL_ZERO;
            nxt.entry_pending = 1'b1;
            nxt.phase         = lobfo_pkg::PH_OFF;
          end
        end
      end
    endcase
    res.phase = nxt.phase;
  end
endmodule

### hdl/led_on_blink_fade_off_sequencer.sv
// Top level of the LED on / blink / fade / off sequencer.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one tick per request,
//   holding the current millisecond time. Master stream (m_tvalid/m_tready/
//   m_tdata) returns one result per tick: phase after the tick, whether a
//   drive value was written, digital or PWM, and its level.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while the block is idle; writes take effect at the next clock edge.
//
// Timing:
//   A tick enters an input register, passes one level of compare/update
//   logic and lands in the result register, where m_tvalid rises. One tick
//   is accepted every cycle while s_tready is high; the rate is set by the
//   combinational state update between the two registers.
//
// Reset (synchronous, rst high): phase ON with entry pending, timers 0,
//   brightness 255, registers at their defaults, both stages empty.
// Backpressure: while m_tready is low a valid result holds; an empty input
//   register still takes one more tick, then s_tready drops until the result moves.
`timescale 1ns / 1ps
`include "led_on_blink_fade_off_sequencer_defines.svh"
module led_on_blink_fade_off_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lobfo_pkg::IN_BITS-1:0]   s_tdata,   // [31:0] now_ms
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lobfo_pkg::OUT_BITS-1:0]  m_tdata,   // [1:0] phase, [2] drive_written,
                                                     // [3] drive_analog, [11:4] drive_level,
                                                     // [15:12] zero
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [15:0]                     cfg_data
);
  logic                  in_valid;
  lobfo_pkg::time_t      in_now;
  logic                  advance;
  lobfo_pkg::cfg_t       cfg;
  lobfo_pkg::seq_state_t st;
  lobfo_pkg::seq_state_t st_next;
  lobfo_pkg::result_t    res_next;
  lobfo_pkg::result_t    res;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= lobfo_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lobfo_pkg::CFG_ON_DURATION:  cfg.on_duration  <= cfg_data;
        lobfo_pkg::CFG_BLINK_PERIOD: cfg.blink_period <= cfg_data;
        lobfo_pkg::CFG_BLINK_TARGET: cfg.blink_target <= cfg_data[2:0];
        lobfo_pkg::CFG_FADE_PERIOD:  cfg.fade_period  <= cfg_data;
        lobfo_pkg::CFG_FADE_STEP:    cfg.fade_step    <= cfg_data[7:0];
        lobfo_pkg::CFG_OFF_DURATION: cfg.off_duration <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage: hold the tick while the result stage is blocked.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_now <= s_tdata[lobfo_pkg::TIME_BITS-1:0];
    end
  end

  lobfo_step u_step (
    .cfg (cfg),
    .cur (st),
    .now (in_now),
    .nxt (st_next),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= lobfo_pkg::STATE_RESET;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res <= res_next;
    end
  end

  assign m_tdata = {4'b0000, res.level, res.analog, res.written, res.phase};

  // A stalled tick in the input register does not change.
  `ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !advance,
               in_valid && $stable(in_now))
  // PWM levels come only from fade, or from the fade step that ends in off.
  `ASSERT_IMPL(a_analog_phase, clk, rst, m_tvalid && res.analog,
               res.phase == lobfo_pkg::PH_FADE || res.phase == lobfo_pkg::PH_OFF)
  // Brightness never rises above full while fading.
  `ASSERT_IMPL(a_bright_max, clk, rst, st.phase == lobfo_pkg::PH_FADE,
               $signed(st.brightness) <= 9'sd255)
endmodule

### tb/lobfo_drive_checker.sv
// Checker for the LED sequencer: predicts each tick's drive result and compares it.
`timescale 1ns / 1ps
module lobfo_drive_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [lobfo_pkg::IN_BITS-1:0]   s_tdata,   // [31:0] now_ms
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [lobfo_pkg::OUT_BITS-1:0]  m_tdata,   // [1:0] phase, [2] drive_written,
                                                     // [3] drive_analog, [11:4] drive_level
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [15:0]                     cfg_data,
  output int                              pending,
  output int                              fail_count
);
  import lobfo_pkg::*;

  cfg_t       regs;
  logic [1:0] ph;
  logic       entering;
  time_t      hold_t;
  time_t      blink_t;
  time_t      fade_t;
  logic       lit;
  logic [2:0] tally;
  int         bright;
  int         errors;
  result_t    drive_q[$];
  result_t    want;
  result_t    got;

  function automatic logic span_passed(time_t now, time_t since, logic [15:0] span);
    time_t gap;
    gap = now - since;
    return gap >= time_t'(span);
  endfunction

  // Advance the sequencer by one tick and return the drive it writes.
  function automatic result_t predict_drive(time_t now);
    result_t r;
    r = '0;
    case (ph)
      PH_ON: begin
        if (entering) begin
          entering = 1'b0;
          hold_t   = now;
        end
        r.written = 1'b1;
        r.level   = LEVEL_FULL;
        if (span_passed(now, hold_t, regs.on_duration)) begin
          entering = 1'b1;
          ph       = PH_BLINK;
        end
      end
      PH_BLINK: begin
        entering = 1'b0;
        if (span_passed(now, blink_t, regs.blink_period)) begin
          blink_t = now;
          lit     = !lit;
          if (lit) tally = tally + 3'd1;
          r.written = 1'b1;
          r.level   = lit ? LEVEL_FULL : LEVEL_ZERO;
        end
        // tally is checked every blink tick, toggled or not
        if (tally == regs.blink_target) begin
          entering = 1'b1;
          tally    = 3'd0;
          ph       = PH_FADE;
        end
      end
      PH_FADE: begin
        if (entering) begin
          entering = 1'b0;
          fade_t   = '0;
          bright   = LEVEL_FULL;
        end
        if (span_passed(now, fade_t, regs.fade_period)) begin
          fade_t    = now;
          r.written = 1'b1;
          r.analog  = 1'b1;
          r.level   = bright[7:0];
          bright    = bright - int'(regs.fade_step);
          if (bright <= 0) begin
            r.level  = LEVEL_ZERO;
            entering = 1'b1;
            ph       = PH_OFF;
          end
        end
      end
      default: begin
        if (entering) begin
          entering = 1'b0;
          hold_t   = now;
        end
        r.written = 1'b1;
        r.level   = LEVEL_ZERO;
        if (span_passed(now, hold_t, regs.off_duration)) begin
          entering = 1'b1;
          ph       = PH_ON;
        end
      end
    endcase
    r.phase = ph;
    return r;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs     = CFG_RESET;
      ph       = PH_ON;
      entering = 1'b1;
      hold_t   = '0;
      blink_t  = '0;
      fade_t   = '0;
      lit      = 1'b0;
      tally    = 3'd0;
      bright   = LEVEL_FULL;
      errors   = 0;
      drive_q.delete();
    end else begin
      if (s_tvalid && s_tready) drive_q.push_back(predict_drive(s_tdata));
      if (m_tvalid && m_tready) begin
        if (drive_q.size() == 0) begin
          errors++;
          $error("result with no request waiting: %h", m_tdata);
        end else begin
          want = drive_q.pop_front();
          got  = m_tdata[11:0];
          check_field("phase", want.phase, got.phase);
          check_field("drive_written", want.written, got.written);
          check_field("drive_analog", want.analog, got.analog);
          check_field("drive_level", want.level, got.level);
          check_field("pad", 0, m_tdata[OUT_BITS-1:12]);
        end
      end
      // the user writes only while idle (the block does not enforce it), so apply after any tick of this edge
      if (cfg_we) begin
        case (cfg_index)
          CFG_ON_DURATION:  regs.on_duration  = cfg_data;
          CFG_BLINK_PERIOD: regs.blink_period = cfg_data;
          CFG_BLINK_TARGET: regs.blink_target = cfg_data[2:0];
          CFG_FADE_PERIOD:  regs.fade_period  = cfg_data;
          CFG_FADE_STEP:    regs.fade_step    = cfg_data[7:0];
          CFG_OFF_DURATION: regs.off_duration = cfg_data;
          default: ;
        endcase
      end
    end
    pending    <= drive_q.size();
    fail_count <= errors;
  end
endmodule

### tb/led_on_blink_fade_off_sequencer_test.sv
// Top of the LED sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module led_on_blink_fade_off_sequencer_test;
  import lobfo_pkg::*;

  localparam int LIMIT = 200000;
  localparam int PHASE_TICKS = 230;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 60;
  // indexes past the last register; the block ignores them
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic [IN_BITS-1:0]   s_tdata = '0;
  logic                 m_tready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [2:0]           cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  wire                  s_tready;
  wire                  m_tvalid;
  wire [OUT_BITS-1:0]   m_tdata;

  int    pending;
  int    fail_count;
  int    cycles = 0;
  int    results_seen = 0;
  int    hold_left = 0;
  logic  hold_done = 1'b0;
  logic  calm = 1'b0;
  time_t clock_ms;

  time_t first_ticks [12] = '{32'd0, 32'd1999, 32'd2000, 32'd2749, 32'd2750, 32'd3500,
                              32'd4250, 32'd5000, 32'd5750, 32'd6500, 32'd7250, 32'hFFFF_FFF0};
  time_t quick_ticks [9] = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5,
                             32'd6, 32'd7};
  time_t stuck_ticks [4] = '{32'h8000_0000, 32'h8000_0001, 32'h0000_FFFF, 32'h7FFF_FFFF};

  led_on_blink_fade_off_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lobfo_drive_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) results_seen <= results_seen + 1;
  end

  // Result side: random stalls, plus one long hold-off to back up the pipe.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 8);
    end
  end

  task automatic send_tick(input time_t t);
    while (!calm && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Hold off until every request has its result, then let the pipe settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] on_ms, input logic [15:0] blink_ms,
                             input logic [15:0] target, input logic [15:0] fade_ms,
                             input logic [15:0] step, input logic [15:0] off_ms);
    write_reg(CFG_ON_DURATION, on_ms);
    write_reg(CFG_BLINK_PERIOD, blink_ms);
    write_reg(CFG_BLINK_TARGET, target);
    write_reg(CFG_FADE_PERIOD, fade_ms);
    write_reg(CFG_FADE_STEP, step);
    write_reg(CFG_OFF_DURATION, off_ms);
    cfg_we <= 1'b0;
  endtask

  task automatic load_small_config();
    load_config(16'($urandom_range(0, 40)), 16'($urandom_range(0, 10)),
                16'($urandom_range(0, 7)), 16'($urandom_range(0, 10)),
                16'($urandom_range(0, 255)), 16'($urandom_range(0, 40)));
  endtask

  // Mostly a clock moving forward; now and then a jump to any time at all.
  task automatic run_ticks(input int n, input int unsigned max_step);
    repeat (n) begin
      if ($urandom_range(99) < 3) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, max_step);
      send_tick(clock_ms);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (first_ticks[i]) send_tick(first_ticks[i]);
    drain();
    // zero spans: every tick moves the sequence on
    load_config(16'd0, 16'd0, 16'd1, 16'd0, 16'd255, 16'd0);
    foreach (quick_ticks[i]) send_tick(quick_ticks[i]);
    drain();
    // step zero keeps fade forever; the run starts in fade, so target zero goes unused
    load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    foreach (stuck_ticks[i]) send_tick(stuck_ticks[i]);
    drain();

    clock_ms = '0;
    for (int k = 0; k < 8; k++) begin
      case (k)
        0: begin
          load_config(16'd2000, 16'd750, 16'd5, 16'd40, 16'd5, 16'd2000);
          run_ticks(PHASE_TICKS, 900);
        end
        2: begin
          load_small_config();
          calm = 1'b1;
          run_ticks(PHASE_TICKS, 6);
          calm = 1'b0;
        end
        3: begin
          write_reg(CFG_SPARE_A, 16'($urandom_range(0, 16'hFFFF)));
          write_reg(CFG_SPARE_B, 16'hFFFF);
          load_config(16'hFFFF, 16'hFFFF, 16'd7, 16'hFFFF, 16'd255, 16'hFFFF);
          run_ticks(PHASE_TICKS, 32'h3FFFF);
        end
        4: begin
          load_config(16'($urandom()), 16'($urandom()), 16'($urandom()),
                      16'($urandom()), 16'($urandom()), 16'($urandom()));
          run_ticks(PHASE_TICKS, 32'h1FFFF);
        end
        5: begin
          load_small_config();
          clock_ms = 32'hFFFF_FF00;
          run_ticks(PHASE_TICKS, 6);
        end
        6: begin
          load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0);
          run_ticks(PHASE_TICKS, 3);
        end
        default: begin
          load_small_config();
          run_ticks(PHASE_TICKS, 6);
        end
      endcase
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
